### rtl/fpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the frustum plane build and cull unit
// Opcodes, controller states, command/status structs and the corner triples.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int NUM_PLANES    = 6;
    localparam int NUM_CORNERS   = 8;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOAD  = 2'd0;
    localparam t_kind KIND_BUILD = 2'd1;
    localparam t_kind KIND_TEST  = 2'd2;

    typedef logic [2:0] t_corner;
    typedef logic [2:0] t_plane;
    typedef logic [1:0] t_comp;
    typedef logic [5:0] t_step;

    localparam t_plane PLANE_LAST = 3'(NUM_PLANES - 1);
    localparam t_comp  COMP_LAST  = 2'd2;

    localparam t_step STEP_RD_LAST    = 6'd3;
    localparam t_step STEP_DIFF_LAST  = 6'd2;
    localparam t_step STEP_CROSS_LAST = 6'd6;
    localparam t_step STEP_ACC_LAST   = 6'd3;
    localparam t_step STEP_SQRT_LAST  = 6'd31;
    localparam t_step STEP_DIV_LAST   = 6'd63;

    typedef enum logic [4:0] {
        OP_IDLE, OP_CAPT, OP_LDC, OP_RD, OP_DIFF, OP_CROSS, OP_MAG, OP_NORM,
        OP_SQSUM, OP_SQINIT, OP_SQRT, OP_DVINIT, OP_DIV, OP_DVEND, OP_DOT,
        OP_DEND, OP_WRZ, OP_TRD, OP_TMUL, OP_TCMP
    } t_dp_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_B_RD, ST_B_DIFF, ST_B_CROSS, ST_B_MAG, ST_B_NORM,
        ST_B_SQSUM, ST_B_SQINIT, ST_B_SQRT, ST_B_DVINIT, ST_B_DIV, ST_B_DVEND,
        ST_B_DOT, ST_B_DEND, ST_B_WRZ, ST_T_RD, ST_T_MUL, ST_T_CMP, ST_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
        t_plane plane;
        t_comp  comp;
        t_step  step;
    } t_dp_cmd;

    typedef struct packed {
        logic zero;
        logic norm_ok;
        logic outside;
    } t_dp_stat;

    // corner k of the triple (a, b, c) that spans plane p
    function automatic t_corner tri_corner(input t_plane p, input logic [1:0] k);
        t_corner c0;
        t_corner c1;
        t_corner c2;
        case (p)
            3'd0: begin c0 = 3'd1; c1 = 3'd5; c2 = 3'd6; end
            3'd1: begin c0 = 3'd4; c1 = 3'd0; c2 = 3'd3; end
            3'd2: begin c0 = 3'd4; c1 = 3'd5; c2 = 3'd1; end
            3'd3: begin c0 = 3'd6; c1 = 3'd7; c2 = 3'd3; end
            3'd4: begin c0 = 3'd5; c1 = 3'd4; c2 = 3'd7; end
            default: begin c0 = 3'd0; c1 = 3'd1; c2 = 3'd2; end
        endcase
        case (k)
            2'd0: return c0;
            2'd1: return c1;
            default: return c2;
        endcase
    endfunction

endpackage
`default_nettype wire

### rtl/fpc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_if: item channels of the frustum unit
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fpc_in_if;
    import fpc_pkg::*;
    logic                valid;
    logic                ready;
    t_kind               kind;
    t_corner             corner_index;
    logic signed [31:0]  coord_x;
    logic signed [31:0]  coord_y;
    logic signed [31:0]  coord_z;
    logic signed [31:0]  radius;

    modport source (output valid, kind, corner_index, coord_x, coord_y, coord_z, radius,
                    input ready);
    modport sink   (input valid, kind, corner_index, coord_x, coord_y, coord_z, radius,
                    output ready);
endinterface

interface fpc_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic status;

    modport source (output valid, inside_res, status, input ready);
    modport sink   (input valid, inside_res, status, output ready);
endinterface
`default_nettype wire

### rtl/fpc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_datapath: arithmetic and stores of the frustum unit
// Corner and plane memories, shared multiplier, accumulator, root and divider.
// ----------------------------------------------------------------------------
module fpc_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  fpc_pkg::t_dp_cmd   i_cmd,
    input  fpc_pkg::t_corner   i_corner_index,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_radius,
    output fpc_pkg::t_dp_stat  o_stat
);
    import fpc_pkg::*;

    localparam logic [62:0]        M_HI  = 63'(1) << 30;
    localparam logic [62:0]        M_LO  = 63'(1) << 29;
    localparam logic [65:0]        HALF  = 66'(1) << (FRAC_BITS - 1);
    localparam logic signed [65:0] D_MAX = 66'sd2147483647;
    localparam logic signed [65:0] D_MIN = -66'sd2147483648;

    logic [95:0]  r_cmem [NUM_CORNERS];
    logic [127:0] r_pmem [NUM_PLANES];
    logic [95:0]  r_crd;
    logic [127:0] r_prd;

    t_corner            r_idx;
    logic signed [31:0] r_x, r_y, r_z, r_r;
    logic signed [31:0] r_cor [3][3];
    logic signed [31:0] r_u [3];
    logic signed [31:0] r_v [3];
    logic signed [63:0] r_cr [3];
    logic [62:0]        r_mag [3];
    logic [62:0]        r_max;
    logic signed [31:0] r_n [3];
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic [63:0]        r_sv, r_sr, r_sbit;
    logic [63:0]        r_num;
    logic [31:0]        r_rem;
    logic [31:0]        r_q;
    logic               r_outside;

    logic [1:0]         w_k;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic [62:0]        w_abs [3];
    logic [62:0]        w_mx01;
    logic signed [65:0] w_dshift, w_lim;
    logic [63:0]        w_t;
    logic [32:0]        w_r;
    logic signed [65:0] w_sabs, w_rq, w_dq;
    logic signed [31:0] w_dsat;
    logic               w_norm_ok;

    function automatic logic signed [31:0] sat31(input logic signed [32:0] v);
        if (v > 33'sd2147483647) return 32'sd2147483647;
        if (v < -33'sd2147483647) return -32'sd2147483647;
        return v[31:0];
    endfunction

    assign w_k = i_cmd.step[1:0];

    // operand selection for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_CROSS: begin
                case (i_cmd.step[2:0])
                    3'd0: begin w_ma = r_u[1]; w_mb = r_v[2]; end
                    3'd1: begin w_ma = r_u[2]; w_mb = r_v[1]; end
                    3'd2: begin w_ma = r_u[2]; w_mb = r_v[0]; end
                    3'd3: begin w_ma = r_u[0]; w_mb = r_v[2]; end
                    3'd4: begin w_ma = r_u[0]; w_mb = r_v[1]; end
                    3'd5: begin w_ma = r_u[1]; w_mb = r_v[0]; end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            OP_SQSUM: begin
                case (w_k)
                    2'd0: w_ma = {2'b00, r_mag[0][29:0]};
                    2'd1: w_ma = {2'b00, r_mag[1][29:0]};
                    2'd2: w_ma = {2'b00, r_mag[2][29:0]};
                    default: w_ma = '0;
                endcase
                w_mb = w_ma;
            end
            OP_DOT: begin
                case (w_k)
                    2'd0: begin w_ma = r_n[0]; w_mb = r_cor[0][0]; end
                    2'd1: begin w_ma = r_n[1]; w_mb = r_cor[0][1]; end
                    2'd2: begin w_ma = r_n[2]; w_mb = r_cor[0][2]; end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            OP_TMUL: begin
                case (w_k)
                    2'd0: begin w_ma = r_prd[127:96]; w_mb = r_x; end
                    2'd1: begin w_ma = r_prd[95:64];  w_mb = r_y; end
                    2'd2: begin w_ma = r_prd[63:32];  w_mb = r_z; end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_cr[i][63] ? 63'(-r_cr[i]) : r_cr[i][62:0];
        end
        w_mx01 = (w_abs[0] > w_abs[1]) ? w_abs[0] : w_abs[1];
    end

    assign w_norm_ok = (r_max < M_HI) && (r_max >= M_LO);
    assign w_dshift  = 66'(signed'(r_prd[31:0])) <<< FRAC_BITS;
    assign w_lim     = 66'(r_r) <<< FRAC_BITS;
    assign w_t       = r_sr + r_sbit;
    assign w_r       = {r_rem, r_num[63]};

    // plane offset: round half away from zero, negate, saturate
    always_comb begin
        w_sabs = r_acc[65] ? -r_acc : r_acc;
        w_rq   = signed'((66'(w_sabs) + HALF) >> FRAC_BITS);
        w_dq   = r_acc[65] ? w_rq : -w_rq;
        if (w_dq > D_MAX) w_dsat = 32'sh7FFFFFFF;
        else if (w_dq < D_MIN) w_dsat = 32'sh80000000;
        else w_dsat = w_dq[31:0];
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LDC) r_cmem[r_idx] <= {r_x, r_y, r_z};
        if (i_cmd.op == OP_RD) r_crd <= r_cmem[tri_corner(i_cmd.plane, w_k)];
        if (i_cmd.op == OP_DEND) r_pmem[i_cmd.plane] <= {r_n[0], r_n[1], r_n[2], w_dsat};
        if (i_cmd.op == OP_WRZ) r_pmem[i_cmd.plane] <= '0;
        if (i_cmd.op == OP_TRD) r_prd <= r_pmem[i_cmd.plane];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (i_cmd.op)
            OP_CAPT: begin
                r_idx     <= i_corner_index;
                r_x       <= i_coord_x;
                r_y       <= i_coord_y;
                r_z       <= i_coord_z;
                r_r       <= i_radius;
                r_outside <= 1'b0;
            end
            OP_RD: begin
                if (w_k != 2'd0) begin
                    r_cor[w_k - 2'd1][0] <= r_crd[95:64];
                    r_cor[w_k - 2'd1][1] <= r_crd[63:32];
                    r_cor[w_k - 2'd1][2] <= r_crd[31:0];
                end
            end
            OP_DIFF: begin
                r_u[w_k] <= sat31(33'(r_cor[1][w_k]) - 33'(r_cor[0][w_k]));
                r_v[w_k] <= sat31(33'(r_cor[2][w_k]) - 33'(r_cor[0][w_k]));
            end
            OP_CROSS: begin
                // product of the previous step: first term loads, second closes
                if (i_cmd.step[0]) r_acc <= 66'(r_prod);
                else if (i_cmd.step[2:1] != 2'd0)
                    r_cr[i_cmd.step[2:1] - 2'd1] <= r_acc[63:0] - r_prod;
            end
            OP_MAG: begin
                for (int i = 0; i < 3; i++) r_mag[i] <= w_abs[i];
                r_max <= (w_mx01 > w_abs[2]) ? w_mx01 : w_abs[2];
            end
            OP_NORM: begin
                if (r_max >= M_HI) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    r_max <= r_max >> 1;
                end else if (r_max < M_LO) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    r_max <= r_max << 1;
                end
            end
            OP_SQSUM, OP_DOT: begin
                if (w_k == 2'd1) r_acc <= 66'(r_prod);
                else if (w_k != 2'd0) r_acc <= r_acc + 66'(r_prod);
            end
            OP_TMUL: begin
                if (w_k == 2'd1) r_acc <= 66'(r_prod) + w_dshift;
                else if (w_k != 2'd0) r_acc <= r_acc + 66'(r_prod);
            end
            OP_SQINIT: begin
                r_sv   <= r_acc[63:0];
                r_sr   <= '0;
                r_sbit <= 64'(1) << 62;
            end
            OP_SQRT: begin
                if (r_sv >= w_t) begin
                    r_sv <= r_sv - w_t;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            OP_DVINIT: begin
                r_num <= (64'(r_mag[i_cmd.comp][29:0]) << FRAC_BITS) + 64'(r_sr[31:1]);
                r_rem <= '0;
                r_q   <= '0;
            end
            OP_DIV: begin
                if (w_r >= {1'b0, r_sr[31:0]}) begin
                    r_rem <= 32'(w_r - {1'b0, r_sr[31:0]});
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_r[31:0];
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_num <= r_num << 1;
            end
            OP_DVEND: begin
                r_n[i_cmd.comp] <= r_cr[i_cmd.comp][63] ? -signed'(r_q) : signed'(r_q);
            end
            OP_TCMP: begin
                if (r_acc > w_lim) r_outside <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.zero    = (r_cr[0] == '0) && (r_cr[1] == '0) && (r_cr[2] == '0);
    assign o_stat.norm_ok = w_norm_ok;
    assign o_stat.outside = r_outside;

endmodule
`default_nettype wire

### rtl/fpc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_ctrl: sequencer of the frustum unit
// Walks load, build and test items through the datapath and holds the result.
// ----------------------------------------------------------------------------
module fpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fpc_pkg::t_kind    i_kind,
    input  fpc_pkg::t_dp_stat i_stat,
    output fpc_pkg::t_dp_cmd  o_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_inside,
    output logic              o_out_status
);
    import fpc_pkg::*;

    t_state r_state, n_state;
    t_plane r_plane, n_plane;
    t_comp  r_comp, n_comp;
    t_step  r_step, n_step;
    logic   r_built, n_built;
    logic   r_res_test, n_res_test;
    logic   r_res_status, n_res_status;
    logic   r_out_valid, n_out_valid;
    logic   r_out_inside, n_out_inside;
    logic   r_out_status, n_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_plane     <= '0;
            r_comp      <= '0;
            r_step      <= '0;
            r_built     <= 1'b0;
            r_res_test  <= 1'b0;
            r_res_status <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_plane     <= n_plane;
            r_comp      <= n_comp;
            r_step      <= n_step;
            r_built     <= n_built;
            r_res_test  <= n_res_test;
            r_res_status <= n_res_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_inside <= n_out_inside;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_plane      = r_plane;
        n_comp       = r_comp;
        n_step       = r_step;
        n_built      = r_built;
        n_res_test   = r_res_test;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_inside = r_out_inside;
        n_out_status = r_out_status;
        o_in_ready   = (r_state == ST_IDLE);
        o_cmd.op     = OP_IDLE;
        o_cmd.plane  = r_plane;
        o_cmd.comp   = r_comp;
        o_cmd.step   = r_step;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op     = OP_CAPT;
                    n_plane      = '0;
                    n_comp       = '0;
                    n_step       = '0;
                    n_res_test   = 1'b0;
                    n_res_status = 1'b0;
                    case (i_kind)
                        KIND_LOAD:  n_state = ST_LOAD;
                        KIND_BUILD: n_state = ST_B_RD;
                        KIND_TEST: begin
                            if (r_built) begin
                                n_res_test = 1'b1;
                                n_state    = ST_T_RD;
                            end else begin
                                n_res_status = 1'b1;
                                n_state      = ST_DONE;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_LOAD: begin
                o_cmd.op = OP_LDC;
                n_state  = ST_DONE;
            end
            ST_B_RD: begin
                o_cmd.op = OP_RD;
                n_step   = r_step + 6'd1;
                if (r_step == STEP_RD_LAST) begin
                    n_step  = '0;
                    n_state = ST_B_DIFF;
                end
            end
            ST_B_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_step   = r_step + 6'd1;
                if (r_step == STEP_DIFF_LAST) begin
                    n_step  = '0;
                    n_state = ST_B_CROSS;
                end
            end
            ST_B_CROSS: begin
                o_cmd.op = OP_CROSS;
                n_step   = r_step + 6'd1;
                if (r_step == STEP_CROSS_LAST) begin
                    n_step  = '0;
                    n_state = ST_B_MAG;
                end
            end
            ST_B_MAG: begin
                // a zero cross product leaves the all-zero plane
                if (i_stat.zero) begin
                    n_state = ST_B_WRZ;
                end else begin
                    o_cmd.op = OP_MAG;
                    n_state  = ST_B_NORM;
                end
            end
            ST_B_NORM: begin
                if (i_stat.norm_ok) n_state = ST_B_SQSUM;
                else o_cmd.op = OP_NORM;
            end
            ST_B_SQSUM: begin
                o_cmd.op = OP_SQSUM;
                n_step   = r_step + 6'd1;
                if (r_step == STEP_ACC_LAST) begin
                    n_step  = '0;
                    n_state = ST_B_SQINIT;
                end
            end
            ST_B_SQINIT: begin
                o_cmd.op = OP_SQINIT;
                n_state  = ST_B_SQRT;
            end
            ST_B_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_step   = r_step + 6'd1;
                if (r_step == STEP_SQRT_LAST) begin
                    n_step  = '0;
                    n_comp  = '0;
                    n_state = ST_B_DVINIT;
                end
            end
            ST_B_DVINIT: begin
                o_cmd.op = OP_DVINIT;
                n_step   = '0;
                n_state  = ST_B_DIV;
            end
            ST_B_DIV: begin
                o_cmd.op = OP_DIV;
                n_step   = r_step + 6'd1;
                if (r_step == STEP_DIV_LAST) begin
                    n_step  = '0;
                    n_state = ST_B_DVEND;
                end
            end
            ST_B_DVEND: begin
                o_cmd.op = OP_DVEND;
                if (r_comp == COMP_LAST) begin
                    n_state = ST_B_DOT;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = ST_B_DVINIT;
                end
            end
            ST_B_DOT: begin
                o_cmd.op = OP_DOT;
                n_step   = r_step + 6'd1;
                if (r_step == STEP_ACC_LAST) begin
                    n_step  = '0;
                    n_state = ST_B_DEND;
                end
            end
            ST_B_DEND, ST_B_WRZ: begin
                o_cmd.op = (r_state == ST_B_DEND) ? OP_DEND : OP_WRZ;
                n_step   = '0;
                n_comp   = '0;
                if (r_plane == PLANE_LAST) begin
                    n_built = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_plane = r_plane + 3'd1;
                    n_state = ST_B_RD;
                end
            end
            ST_T_RD: begin
                o_cmd.op = OP_TRD;
                n_step   = '0;
                n_state  = ST_T_MUL;
            end
            ST_T_MUL: begin
                o_cmd.op = OP_TMUL;
                n_step   = r_step + 6'd1;
                if (r_step == STEP_ACC_LAST) begin
                    n_step  = '0;
                    n_state = ST_T_CMP;
                end
            end
            ST_T_CMP: begin
                o_cmd.op = OP_TCMP;
                if (r_plane == PLANE_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_plane = r_plane + 3'd1;
                    n_state = ST_T_RD;
                end
            end
            ST_DONE: begin
                // hold until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = r_res_test && !i_stat.outside;
                    n_out_status = r_res_status;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_inside = r_out_inside;
    assign o_out_status = r_out_status;

    a_inside_xor_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_inside && r_out_status))
        else $error("result reports inside together with not-built status");

    a_build_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_B_DEND || r_state == ST_B_WRZ) && r_plane == PLANE_LAST)
        |=> r_built)
        else $error("last plane written but planes not marked built");

    a_inside_needs_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_inside) |-> r_built)
        else $error("inside result before any build");

endmodule
`default_nettype wire

### rtl/frustum_plane_build_and_sphere_cull_unit.sv
`default_nettype none
// Items: one at a time; the next item enters once its result is registered.
// Reset: synchronous, active low; clears the sequencer, the built flag and the output
//   valid. Corner and plane stores are not cleared.
// ----------------------------------------------------------------------------
// frustum_plane_build_and_sphere_cull_unit: six-plane frustum cull, fixed point
// Stores eight frustum corners, builds six normalized planes, tests spheres.
// ----------------------------------------------------------------------------
module frustum_plane_build_and_sphere_cull_unit #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpc_in_if.sink     i_in,
    fpc_out_if.source  o_out
);
    import fpc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;
    logic     w_out_inside;
    logic     w_out_status;

    // The controller sequences every item as a series of datapath commands:
    // a load writes one corner entry, a build walks all six planes through
    // difference, cross product, normalize, root, divide and offset, a test
    // walks the six stored planes through three products plus the offset.
    fpc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (w_in_ready),
        .i_kind       (i_in.kind),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_out_valid  (w_out_valid),
        .i_out_ready  (o_out.ready),
        .o_out_inside (w_out_inside),
        .o_out_status (w_out_status)
    );

    // The datapath captures the item payload on acceptance and owns the
    // corner and plane memories and all arithmetic.
    fpc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_corner_index (i_in.corner_index),
        .i_coord_x      (i_in.coord_x),
        .i_coord_y      (i_in.coord_y),
        .i_coord_z      (i_in.coord_z),
        .i_radius       (i_in.radius),
        .o_stat         (w_stat)
    );

    // Output register sits in the controller; drive the result channel.
    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = w_out_valid;
    assign o_out.inside_res = w_out_inside;
    assign o_out.status     = w_out_status;

endmodule
`default_nettype wire
